// File: rtl/dnms_pkg.sv
`default_nettype none
package dnms_pkg;

	localparam int MAX_BOXES   = 64;
	localparam int IDX_W       = $clog2(MAX_BOXES);
	localparam int CNT_W       = IDX_W + 1;
	localparam int MAX_CLASSES = 80;
	localparam int CLS_W       = 7;
	localparam int WORD_W      = 87;
	localparam int DIV_W       = 28;
	localparam int DEN_W       = 14;
	localparam int APB_AW      = 5;

	typedef enum logic [2:0] {
		REG_SCORE_THR   = 3'd0,
		REG_OVERLAP_THR = 3'd1,
		REG_MODEL_W     = 3'd2,
		REG_MODEL_H     = 3'd3,
		REG_CLASS_CNT   = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [15:0] score_thr;
		logic [15:0] overlap_thr;
		logic [12:0] model_w;
		logic [12:0] model_h;
		logic [6:0]  class_cnt;
	} cfg_t;

	typedef struct packed {
		logic score_acc;
		logic box_acc;
		logic div_start;
		logic div_save;
		logic cand_wr;
		logic idx_clr;
		logic idx_inc;
		logic scan_clr;
		logic scan_cmp;
		logic rd_a;
		logic a_mark;
		logic a_latch;
		logic push;
		logic sup_latch;
		logic sup_set;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic best_ok;
		logic store_full;
		logic fe;
		logic div_done;
		logic div_last;
		logic idx_end;
		logic found;
		logic a_supp;
		logic j_skip;
		logic out_free;
		logic pend_valid;
	} status_t;

endpackage
`default_nettype wire

// File: rtl/detection_decode_nms_top.sv
// Channel   Dir  Handshake            Payload
// s_axis    in   tvalid/tready        tdata score,cx,cy,w,h; tuser op; tlast frame_end
// m_axis    out  tvalid/tready        tdata box,conf,class; tuser valid,overflow; tlast last
// apb       in   psel/penable/pready  five config registers at 4*i
//
// A score item never stalls the input. A box item that qualifies runs four 28-step
// divides through one shared radix-2 divider, each started on its own and saved when done.
// At frame end each of the n stored boxes is picked once. A pick scans the whole store,
// and a kept box then runs the IoU check against each remaining candidate, all through
// one store read port.
// Reset is asynchronous; control state clears at once and the store needs no clearing.
// A result waits in the output register while the master side stalls.
`default_nettype none
module detection_decode_nms_top
	import dnms_pkg::*;
(
	input  wire               clk,
	input  wire               arst_n,
	input  wire               psel,
	input  wire               penable,
	input  wire               pwrite,
	input  wire  [APB_AW-1:0] paddr,
	input  wire  [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  wire               s_axis_tvalid,
	output logic              s_axis_tready,
	// score[15:0], center_x[31:16], center_y[47:32], box_width[63:48], box_height[79:64]
	input  wire  [79:0]       s_axis_tdata,
	// op[0]
	input  wire  [0:0]        s_axis_tuser,
	input  wire               s_axis_tlast,
	output logic              m_axis_tvalid,
	input  wire               m_axis_tready,
	// left[15:0], top[31:16], norm_width[47:32], norm_height[63:48],
	// confidence[79:64], class index[86:80], zero[87]
	output logic [87:0]       m_axis_tdata,
	// valid_res[0], overflow[1]
	output logic [1:0]        m_axis_tuser,
	output logic              m_axis_tlast
);

	cfg_t    cfg;
	cmd_t    cmd;
	status_t sts;

	dnms_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	dnms_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_op    (s_axis_tuser[0]),
		.in_last  (s_axis_tlast),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	dnms_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (s_axis_tdata),
		.in_last   (s_axis_tlast),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_user  (m_axis_tuser),
		.out_last  (m_axis_tlast)
	);

endmodule
`default_nettype wire

// File: rtl/dnms_ram.sv
`default_nettype none
module dnms_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire  [$clog2(DEPTH)-1:0] waddr,
	input  wire  [WIDTH-1:0]         wdata,
	input  wire  [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// File: rtl/dnms_div.sv
`default_nettype none
module dnms_div
	import dnms_pkg::*;
(
	input  wire               clk,
	input  wire               arst_n,
	input  wire               start,
	input  wire  [DIV_W-1:0]  dividend,
	input  wire  [DEN_W-1:0]  divisor,
	output logic [DIV_W-1:0]  quotient,
	output logic              done
);

	localparam int CNT_DW = $clog2(DIV_W);

	logic [DEN_W-1:0]  rem_q;
	logic [DIV_W-1:0]  quo_q;
	logic [CNT_DW-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DEN_W:0]    rem_sh;
	logic [DEN_W:0]    diff;
	logic              ge;

	// One quotient bit per cycle; the dividend shifts out as quotient bits shift in.
	assign rem_sh = {rem_q, quo_q[DIV_W-1]};
	assign diff   = rem_sh - {1'b0, divisor};
	assign ge     = rem_sh >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_DW'(DIV_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], ge};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule
`default_nettype wire

// File: rtl/dnms_cfg.sv
`default_nettype none
module dnms_cfg
	import dnms_pkg::*;
(
	input  wire               clk,
	input  wire               arst_n,
	input  wire               psel,
	input  wire               penable,
	input  wire               pwrite,
	input  wire  [APB_AW-1:0] paddr,
	input  wire  [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t       cfg_q;
	logic [2:0] idx;
	logic       wr;

	assign idx    = paddr[4:2];
	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.score_thr   <= 16'd16384;
			cfg_q.overlap_thr <= 16'd29491;
			cfg_q.model_w     <= 13'd640;
			cfg_q.model_h     <= 13'd640;
			cfg_q.class_cnt   <= 7'd80;
		end else if (wr) begin
			case (idx)
				REG_SCORE_THR:   cfg_q.score_thr   <= pwdata[15:0];
				REG_OVERLAP_THR: cfg_q.overlap_thr <= pwdata[15:0];
				REG_MODEL_W:     cfg_q.model_w     <= pwdata[12:0];
				REG_MODEL_H:     cfg_q.model_h     <= pwdata[12:0];
				REG_CLASS_CNT:   cfg_q.class_cnt   <= pwdata[6:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_SCORE_THR:   prdata = {16'd0, cfg_q.score_thr};
			REG_OVERLAP_THR: prdata = {16'd0, cfg_q.overlap_thr};
			REG_MODEL_W:     prdata = {19'd0, cfg_q.model_w};
			REG_MODEL_H:     prdata = {19'd0, cfg_q.model_h};
			REG_CLASS_CNT:   prdata = {25'd0, cfg_q.class_cnt};
			default:         prdata = 32'd0;
		endcase
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

// File: rtl/dnms_datapath.sv
`default_nettype none
module dnms_datapath
	import dnms_pkg::*;
(
	input  wire          clk,
	input  wire          arst_n,
	input  cfg_t         cfg,
	input  cmd_t         cmd,
	output status_t      sts,
	input  wire  [79:0]  in_data,
	input  wire          in_last,
	output logic         out_valid,
	input  wire          out_ready,
	output logic [87:0]  out_data,
	output logic [1:0]   out_user,
	output logic         out_last
);

	// ---------------- anchor decode ----------------
	logic [15:0]      best_score_q;
	logic [CLS_W-1:0] best_class_q;
	logic [7:0]       class_ctr_q;
	logic [7:0]       limit;
	logic [15:0]      in_score;

	assign in_score = in_data[15:0];
	assign limit = ({1'b0, cfg.class_cnt} < 8'(MAX_CLASSES)) ? {1'b0, cfg.class_cnt}
		: 8'(MAX_CLASSES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_score_q <= '0;
			best_class_q <= '0;
			class_ctr_q  <= '0;
		end else if (cmd.box_acc) begin
			best_score_q <= '0;
			best_class_q <= '0;
			class_ctr_q  <= '0;
		end else if (cmd.score_acc && (class_ctr_q < limit)) begin
			if (in_score > best_score_q) begin
				best_score_q <= in_score;
				best_class_q <= class_ctr_q[CLS_W-1:0];
			end
			class_ctr_q <= class_ctr_q + 1'b1;
		end
	end

	logic [15:0]      cx_q, cy_q, w_q, h_q;
	logic [15:0]      cur_score_q;
	logic [CLS_W-1:0] cur_class_q;
	logic             fe_q;

	always_ff @(posedge clk) begin
		if (cmd.box_acc) begin
			cx_q        <= in_data[31:16];
			cy_q        <= in_data[47:32];
			w_q         <= in_data[63:48];
			h_q         <= in_data[79:64];
			cur_score_q <= best_score_q;
			cur_class_q <= best_class_q;
			fe_q        <= in_last;
		end
	end

	// ---------------- candidate store control ----------------
	logic [CNT_W-1:0] count_q;
	logic             overflow_q;
	logic             best_ok;
	logic             store_full;

	assign best_ok    = best_score_q >= cfg.score_thr;
	assign store_full = count_q == CNT_W'(MAX_BOXES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			overflow_q <= 1'b0;
		end else if (cmd.finish) begin
			count_q    <= '0;
			overflow_q <= 1'b0;
		end else begin
			if (cmd.box_acc && best_ok && store_full) begin
				overflow_q <= 1'b1;
			end
			if (cmd.cand_wr) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	// ---------------- normalization divides ----------------
	// Step 0/1: corner x/y, step 2/3: width/height; all share one divider.
	logic [1:0]        div_k_q;
	logic [12:0]       mw_eff, mh_eff, m_sel;
	logic [15:0]       c_sel, sz_sel;
	logic signed [29:0] c_s, sz_s, m_s, num;
	logic [DEN_W-1:0]  den;
	logic [29:0]       mag;
	logic              neg;
	logic [DIV_W-1:0]  quot;
	logic              div_done;
	logic [15:0]       div_res;

	assign mw_eff = (cfg.model_w == '0) ? 13'd1 : cfg.model_w;
	assign mh_eff = (cfg.model_h == '0) ? 13'd1 : cfg.model_h;
	assign m_sel  = div_k_q[0] ? mh_eff : mw_eff;
	assign c_sel  = div_k_q[0] ? cy_q : cx_q;
	assign sz_sel = div_k_q[0] ? h_q : w_q;
	assign c_s    = $signed({14'd0, c_sel});
	assign sz_s   = $signed({14'd0, sz_sel});
	assign m_s    = $signed({17'd0, m_sel});
	assign den    = {m_sel, 1'b0};

	always_comb begin
		if (div_k_q[1]) begin
			num = (sz_s <<< 11) + m_s;
		end else begin
			num = (((c_s <<< 1) - sz_s) <<< 10) + m_s;
		end
	end

	// A negative numerator divides its magnitude rounded up, to give the floor.
	assign neg = num[29];
	assign mag = neg ? (30'd0 - 30'(num) + {16'd0, den} - 30'd1) : 30'(num);

	dnms_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (mag[DIV_W-1:0]),
		.divisor  (den),
		.quotient (quot),
		.done     (div_done)
	);

	always_comb begin
		if (div_k_q[1]) begin
			div_res = (quot > DIV_W'(65535)) ? 16'hFFFF : quot[15:0];
		end else if (neg) begin
			div_res = (quot > DIV_W'(32768)) ? 16'h8000 : 16'(16'd0 - quot[15:0]);
		end else begin
			div_res = (quot > DIV_W'(32767)) ? 16'h7FFF : quot[15:0];
		end
	end

	logic [15:0] l_q, t_q, nw_q, nh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_k_q <= '0;
		end else if (cmd.box_acc) begin
			div_k_q <= '0;
		end else if (cmd.div_save) begin
			div_k_q <= div_k_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_save) begin
			case (div_k_q)
				2'd0:    l_q  <= div_res;
				2'd1:    t_q  <= div_res;
				2'd2:    nw_q <= div_res;
				default: nh_q <= div_res;
			endcase
		end
	end

	// ---------------- candidate memory ----------------
	logic [CNT_W-1:0]  idx_q;
	logic [IDX_W-1:0]  ix;
	logic [IDX_W-1:0]  a_q;
	logic [IDX_W-1:0]  raddr;
	logic [WORD_W-1:0] rdata;
	logic [WORD_W-1:0] wdata;

	assign ix    = idx_q[IDX_W-1:0];
	assign raddr = cmd.rd_a ? a_q : ix;
	assign wdata = {cur_class_q, cur_score_q, nh_q, nw_q, t_q, l_q};

	dnms_ram #(
		.WIDTH (WORD_W),
		.DEPTH (MAX_BOXES)
	) u_store (
		.clk   (clk),
		.we    (cmd.cand_wr),
		.waddr (count_q[IDX_W-1:0]),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// ---------------- selection scan ----------------
	logic [MAX_BOXES-1:0] done_q;
	logic [MAX_BOXES-1:0] supp_q;
	logic                 found_q;
	logic [15:0]          scan_best_q;
	logic [15:0]          rd_score;
	logic                 ovl;

	assign rd_score = rdata[79:64];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			found_q     <= 1'b0;
			scan_best_q <= '0;
			a_q         <= '0;
			done_q      <= '0;
			supp_q      <= '0;
		end else begin
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.scan_clr) begin
				found_q <= 1'b0;
			end else if (cmd.scan_cmp && !done_q[ix]
					&& (!found_q || (rd_score > scan_best_q))) begin
				found_q     <= 1'b1;
				scan_best_q <= rd_score;
				a_q         <= ix;
			end
			if (cmd.finish) begin
				done_q <= '0;
				supp_q <= '0;
			end else begin
				if (cmd.a_mark) begin
					done_q[a_q] <= 1'b1;
				end
				if (cmd.sup_set && ovl) begin
					supp_q[ix] <= 1'b1;
				end
			end
		end
	end

	// ---------------- chosen box and pending result ----------------
	logic [15:0]      a_l_q, a_t_q, a_w_q, a_h_q, a_score_q;
	logic [CLS_W-1:0] a_class_q;
	logic             pend_valid_q;

	always_ff @(posedge clk) begin
		if (cmd.a_latch) begin
			a_l_q     <= rdata[15:0];
			a_t_q     <= rdata[31:16];
			a_w_q     <= rdata[47:32];
			a_h_q     <= rdata[63:48];
			a_score_q <= rdata[79:64];
			a_class_q <= rdata[86:80];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			pend_valid_q <= 1'b0;
		end else if (cmd.a_latch) begin
			pend_valid_q <= 1'b1;
		end
	end

	// ---------------- overlap pipeline ----------------
	logic [15:0] b_l_q, b_t_q, b_w_q, b_h_q;

	always_ff @(posedge clk) begin
		if (cmd.sup_latch) begin
			b_l_q <= rdata[15:0];
			b_t_q <= rdata[31:16];
			b_w_q <= rdata[47:32];
			b_h_q <= rdata[63:48];
		end
	end

	logic signed [17:0] al, ar, at, ab, bl, br, bt, bb, x1, x2, y1, y2;
	logic [16:0]        iw, ih;

	assign al = $signed({{2{a_l_q[15]}}, a_l_q});
	assign at = $signed({{2{a_t_q[15]}}, a_t_q});
	assign bl = $signed({{2{b_l_q[15]}}, b_l_q});
	assign bt = $signed({{2{b_t_q[15]}}, b_t_q});
	assign ar = al + $signed({2'b00, a_w_q});
	assign ab = at + $signed({2'b00, a_h_q});
	assign br = bl + $signed({2'b00, b_w_q});
	assign bb = bt + $signed({2'b00, b_h_q});
	assign x1 = (al > bl) ? al : bl;
	assign y1 = (at > bt) ? at : bt;
	assign x2 = (ar < br) ? ar : br;
	assign y2 = (ab < bb) ? ab : bb;
	assign iw = (x2 > x1) ? 17'(x2 - x1) : 17'd0;
	assign ih = (y2 > y1) ? 17'(y2 - y1) : 17'd0;

	logic [16:0] iw_s1, ih_s1;
	logic [31:0] area_a_s1, area_a_s2, area_b_s2;
	logic [33:0] inter_s2, inter_s3;
	logic [32:0] uni_s3;
	logic [48:0] prod;

	always_ff @(posedge clk) begin
		iw_s1     <= iw;
		ih_s1     <= ih;
		area_a_s1 <= 32'(a_w_q) * 32'(a_h_q);
		inter_s2  <= 34'(iw_s1) * 34'(ih_s1);
		area_b_s2 <= 32'(b_w_q) * 32'(b_h_q);
		area_a_s2 <= area_a_s1;
		// The intersection never exceeds either area, so the union never goes negative.
		uni_s3    <= {1'b0, area_a_s2} + {1'b0, area_b_s2} - inter_s2[32:0];
		inter_s3  <= inter_s2;
	end

	assign prod = 49'(cfg.overlap_thr) * 49'(uni_s3);
	assign ovl  = (uni_s3 != '0) && ({inter_s3, 16'd0} > {1'b0, prod});

	// ---------------- output register ----------------
	logic        out_valid_q;
	logic [87:0] out_data_q;
	logic [1:0]  out_user_q;
	logic        out_last_q;
	logic        out_free;
	logic [87:0] pend_data;

	assign out_free  = !out_valid_q || out_ready;
	assign pend_data = {1'b0, a_class_q, a_score_q, a_h_q, a_w_q, a_t_q, a_l_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push || cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			out_data_q <= pend_data;
			out_user_q <= {overflow_q, 1'b1};
			out_last_q <= 1'b0;
		end else if (cmd.finish) begin
			out_data_q <= pend_valid_q ? pend_data : 88'd0;
			out_user_q <= {overflow_q, pend_valid_q};
			out_last_q <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_user  = out_user_q;
	assign out_last  = out_last_q;

	// ---------------- status ----------------
	assign sts.best_ok    = best_ok;
	assign sts.store_full = store_full;
	assign sts.fe         = fe_q;
	assign sts.div_done   = div_done;
	assign sts.div_last   = div_k_q == 2'd3;
	assign sts.idx_end    = idx_q >= count_q;
	assign sts.found      = found_q;
	assign sts.a_supp     = supp_q[a_q];
	assign sts.j_skip     = done_q[ix] || supp_q[ix];
	assign sts.out_free   = out_free;
	assign sts.pend_valid = pend_valid_q;

endmodule
`default_nettype wire

// File: rtl/dnms_ctrl.sv
`default_nettype none
module dnms_ctrl
	import dnms_pkg::*;
(
	input  wire      clk,
	input  wire      arst_n,
	input  wire      in_valid,
	input  wire      in_op,
	input  wire      in_last,
	output logic     in_ready,
	input  status_t  sts,
	output cmd_t     cmd
);

	typedef enum logic [18:0] {
		ST_IDLE      = 19'h00001,
		ST_DIV_GO    = 19'h00002,
		ST_DIV_WAIT  = 19'h00004,
		ST_STORE     = 19'h00008,
		ST_NMS_START = 19'h00010,
		ST_SCAN_RD   = 19'h00020,
		ST_SCAN_CMP  = 19'h00040,
		ST_SCAN_END  = 19'h00080,
		ST_A_RD      = 19'h00100,
		ST_PUSH      = 19'h00200,
		ST_A_LAT     = 19'h00400,
		ST_SUP_CHK   = 19'h00800,
		ST_SUP_RD    = 19'h01000,
		ST_SUP_LAT   = 19'h02000,
		ST_SUP_W1    = 19'h04000,
		ST_SUP_W2    = 19'h08000,
		ST_SUP_W3    = 19'h10000,
		ST_SUP_SET   = 19'h20000,
		ST_FINISH    = 19'h40000
	} state_t;

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		cmd       = '0;
		in_ready  = 1'b0;
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (!in_op) begin
						cmd.score_acc = 1'b1;
					end else begin
						cmd.box_acc = 1'b1;
						if (sts.best_ok && !sts.store_full) begin
							state_nxt = ST_DIV_GO;
						end else if (in_last) begin
							state_nxt = ST_NMS_START;
						end
					end
				end
			end
			ST_DIV_GO: begin
				cmd.div_start = 1'b1;
				state_nxt     = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (sts.div_done) begin
					cmd.div_save = 1'b1;
					state_nxt    = sts.div_last ? ST_STORE : ST_DIV_GO;
				end
			end
			ST_STORE: begin
				cmd.cand_wr = 1'b1;
				state_nxt   = sts.fe ? ST_NMS_START : ST_IDLE;
			end
			ST_NMS_START: begin
				cmd.idx_clr  = 1'b1;
				cmd.scan_clr = 1'b1;
				state_nxt    = ST_SCAN_RD;
			end
			ST_SCAN_RD: begin
				state_nxt = sts.idx_end ? ST_SCAN_END : ST_SCAN_CMP;
			end
			ST_SCAN_CMP: begin
				cmd.scan_cmp = 1'b1;
				cmd.idx_inc  = 1'b1;
				state_nxt    = ST_SCAN_RD;
			end
			ST_SCAN_END: begin
				if (!sts.found) begin
					state_nxt = ST_FINISH;
				end else begin
					cmd.a_mark = 1'b1;
					state_nxt  = sts.a_supp ? ST_NMS_START : ST_A_RD;
				end
			end
			ST_A_RD: begin
				cmd.rd_a  = 1'b1;
				state_nxt = ST_PUSH;
			end
			ST_PUSH: begin
				// The previous kept box leaves only now that a later one is known.
				cmd.rd_a = 1'b1;
				if (!sts.pend_valid) begin
					state_nxt = ST_A_LAT;
				end else if (sts.out_free) begin
					cmd.push  = 1'b1;
					state_nxt = ST_A_LAT;
				end
			end
			ST_A_LAT: begin
				cmd.rd_a    = 1'b1;
				cmd.a_latch = 1'b1;
				cmd.idx_clr = 1'b1;
				state_nxt   = ST_SUP_CHK;
			end
			ST_SUP_CHK: begin
				if (sts.idx_end) begin
					state_nxt = ST_NMS_START;
				end else if (sts.j_skip) begin
					cmd.idx_inc = 1'b1;
				end else begin
					state_nxt = ST_SUP_RD;
				end
			end
			ST_SUP_RD: begin
				state_nxt = ST_SUP_LAT;
			end
			ST_SUP_LAT: begin
				cmd.sup_latch = 1'b1;
				state_nxt     = ST_SUP_W1;
			end
			ST_SUP_W1: begin
				state_nxt = ST_SUP_W2;
			end
			ST_SUP_W2: begin
				state_nxt = ST_SUP_W3;
			end
			ST_SUP_W3: begin
				state_nxt = ST_SUP_SET;
			end
			ST_SUP_SET: begin
				cmd.sup_set = 1'b1;
				cmd.idx_inc = 1'b1;
				state_nxt   = ST_SUP_CHK;
			end
			ST_FINISH: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_nxt  = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// File: rtl/dnms_checker.sv
`default_nettype none
module dnms_checker
	import dnms_pkg::*;
(
	input wire              clk,
	input wire              arst_n,
	input wire              s_axis_tvalid,
	input wire              s_axis_tready,
	input wire [0:0]        s_axis_tuser,
	input wire              m_axis_tvalid,
	input wire              m_axis_tready,
	input wire [87:0]       m_axis_tdata,
	input wire [1:0]        m_axis_tuser,
	input wire              m_axis_tlast
);

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("result changed while stalled");

	// The empty-frame result always closes the frame.
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast)
		else $error("empty result without last");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 88'd0)
		else $error("empty result with nonzero payload");

	// A score transfer never starts any long operation.
	a_score_fast: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && !s_axis_tuser[0] |=> s_axis_tready)
		else $error("input stalled after a score transfer");

endmodule

bind detection_decode_nms_top dnms_checker u_chk (.*);
`default_nettype wire

// File: tb/sv/tb_detection_decode_nms_top.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_detection_decode_nms_top;
	import dnms_pkg::*;

	localparam int WDOG_LIMIT = 200000;
	localparam int SETTLE_CYC = 300;
	localparam int HOLD_CYC   = 3000;
	localparam int MAX_OUT    = 64;

	typedef struct {
		bit          op;
		logic [15:0] score;
		logic [15:0] cx;
		logic [15:0] cy;
		logic [15:0] w;
		logic [15:0] h;
		bit          fe;
	} det_item_t;

	typedef struct {
		logic signed [15:0] left;
		logic signed [15:0] top;
		logic [15:0]        nw;
		logic [15:0]        nh;
		logic [15:0]        conf;
		logic [6:0]         cls;
	} cand_t;

	typedef struct {
		bit    valid;
		cand_t box;
		bit    ovf;
		bit    last;
	} det_res_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [APB_AW-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [79:0] s_axis_tdata = '0;
	logic [0:0]  s_axis_tuser = '0;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [87:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;

	detection_decode_nms_top dut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Shadow configuration and decoder state.
	logic [15:0] thr_score = 16384, thr_overlap = 29491;
	logic [12:0] mdl_w = 640, mdl_h = 640;
	logic [6:0]  cls_cnt = 80;
	logic [15:0] best_sc;
	logic [6:0]  best_cl, cls_seen;
	cand_t       cands[MAX_BOXES];
	int          cand_n;
	bit          ovf_flag;

	det_item_t det_item_q[$];
	det_res_t  box_expect_q[$];
	int        err_cnt, items_sent, results_seen, frames_done, empty_frames;
	bit        calm, hold_req, hold_done;
	int        src_gap, snk_gap, hold_cnt, idle_cyc;
	int        base_x[3], base_y[3];

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch: %s got %0d expected %0d (result %0d)", what, got, want, results_seen);
		err_cnt++;
	endtask

	function automatic longint round_half_up(longint n, longint d);
		longint num, den;
		num = 2 * n + d;
		den = 2 * d;
		if (num >= 0) return num / den;
		return -((-num + den - 1) / den);
	endfunction

	function automatic longint clip(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic bit suppresses(cand_t a, cand_t b);
		longint x1, y1, x2, y2, iw, ih, inter, uni;
		x1 = a.left > b.left ? a.left : b.left;
		y1 = a.top > b.top ? a.top : b.top;
		x2 = (a.left + longint'(a.nw)) < (b.left + longint'(b.nw)) ?
			a.left + longint'(a.nw) : b.left + longint'(b.nw);
		y2 = (a.top + longint'(a.nh)) < (b.top + longint'(b.nh)) ?
			a.top + longint'(a.nh) : b.top + longint'(b.nh);
		iw = x2 > x1 ? x2 - x1 : 0;
		ih = y2 > y1 ? y2 - y1 : 0;
		inter = iw * ih;
		uni = longint'(a.nw) * a.nh + longint'(b.nw) * b.nh - inter;
		if (uni == 0) return 1'b0;
		return inter * 65536 > longint'(thr_overlap) * uni;
	endfunction

	task automatic emit_kept_boxes();
		int idx[MAX_BOXES];
		bit sup[MAX_BOXES];
		int i, j, key, a, emitted;
		det_res_t r;
		emitted = 0;
		for (i = 0; i < MAX_BOXES; i++) sup[i] = 1'b0;
		for (i = 0; i < cand_n; i++) begin
			key = i;
			j = i;
			while (j > 0 && cands[idx[j - 1]].conf < cands[key].conf) begin
				idx[j] = idx[j - 1];
				j--;
			end
			idx[j] = key;
		end
		for (i = 0; i < cand_n; i++) begin
			if (sup[i]) continue;
			a = idx[i];
			if (emitted < MAX_OUT) begin
				r.valid = 1'b1;
				r.box = cands[a];
				r.ovf = ovf_flag;
				r.last = 1'b0;
				box_expect_q.insert(box_expect_q.size(), r);
				emitted++;
			end
			for (j = i + 1; j < cand_n; j++)
				if (!sup[j] && suppresses(cands[a], cands[idx[j]])) sup[j] = 1'b1;
		end
		if (emitted == 0) begin
			r.valid = 1'b0;
			r.box = '{default: 0};
			r.ovf = ovf_flag;
			r.last = 1'b0;
			box_expect_q.insert(box_expect_q.size(), r);
			empty_frames++;
		end
		box_expect_q[box_expect_q.size() - 1].last = 1'b1;
		cand_n = 0;
		ovf_flag = 1'b0;
		frames_done++;
	endtask

	task automatic decode_item(input det_item_t it);
		int limit;
		longint mw, mh;
		cand_t c;
		limit = cls_cnt < MAX_CLASSES ? cls_cnt : MAX_CLASSES;
		if (!it.op) begin
			if (cls_seen < limit) begin
				if (it.score > best_sc) begin
					best_sc = it.score;
					best_cl = cls_seen;
				end
				cls_seen++;
			end
			return;
		end
		mw = mdl_w == 0 ? 1 : mdl_w;
		mh = mdl_h == 0 ? 1 : mdl_h;
		if (best_sc >= thr_score) begin
			if (cand_n >= MAX_BOXES) begin
				ovf_flag = 1'b1;
			end else begin
				c.left = 16'(clip(round_half_up((2 * longint'(it.cx) - it.w) * 512, mw),
					-32768, 32767));
				c.top = 16'(clip(round_half_up((2 * longint'(it.cy) - it.h) * 512, mh),
					-32768, 32767));
				c.nw = 16'(clip(round_half_up(longint'(it.w) * 1024, mw), 0, 65535));
				c.nh = 16'(clip(round_half_up(longint'(it.h) * 1024, mh), 0, 65535));
				c.conf = best_sc;
				c.cls = best_cl;
				cands[cand_n] = c;
				cand_n++;
			end
		end
		best_sc = 0;
		best_cl = 0;
		cls_seen = 0;
		if (it.fe) emit_kept_boxes();
	endtask

	// Sender: one item per transfer, with random gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			src_gap <= 0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			det_item_t it;
			if (s_axis_tvalid) begin
				it.op = s_axis_tuser[0];
				{it.h, it.w, it.cy, it.cx, it.score} = s_axis_tdata;
				it.fe = s_axis_tlast;
				decode_item(it);
			end
			if (src_gap > 0) begin
				src_gap <= src_gap - 1;
				s_axis_tvalid <= 1'b0;
			end else if (det_item_q.size() > 0) begin
				if (!calm && $urandom_range(0, 9) == 0) begin
					src_gap <= $urandom_range(0, 10);
					s_axis_tvalid <= 1'b0;
				end else begin
					it = det_item_q.pop_front();
					s_axis_tdata <= {it.h, it.w, it.cy, it.cx, it.score};
					s_axis_tuser <= it.op;
					s_axis_tlast <= it.fe;
					s_axis_tvalid <= 1'b1;
				end
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Receiver ready: random stalls, plus one long hold-off on request.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			snk_gap <= 0;
			hold_cnt <= 0;
			hold_done <= 1'b0;
		end else if (hold_req && !hold_done) begin
			m_axis_tready <= 1'b0;
			hold_cnt <= hold_cnt + 1;
			if (hold_cnt == HOLD_CYC) hold_done <= 1'b1;
		end else if (snk_gap > 0) begin
			snk_gap <= snk_gap - 1;
			m_axis_tready <= 1'b0;
		end else if (!calm && $urandom_range(0, 7) == 0) begin
			snk_gap <= $urandom_range(0, 10);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Result checker.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			det_res_t e;
			if (box_expect_q.size() == 0) begin
				report_mismatch("unexpected result transfer", 1, 0);
			end else begin
				e = box_expect_q.pop_front();
				if (m_axis_tuser[0] !== e.valid) report_mismatch("valid_res", m_axis_tuser[0], e.valid);
				if (m_axis_tdata[15:0] !== e.box.left)
					report_mismatch("left", $signed(m_axis_tdata[15:0]), e.box.left);
				if (m_axis_tdata[31:16] !== e.box.top)
					report_mismatch("top", $signed(m_axis_tdata[31:16]), e.box.top);
				if (m_axis_tdata[47:32] !== e.box.nw) report_mismatch("norm_width", m_axis_tdata[47:32], e.box.nw);
				if (m_axis_tdata[63:48] !== e.box.nh) report_mismatch("norm_height", m_axis_tdata[63:48], e.box.nh);
				if (m_axis_tdata[79:64] !== e.box.conf) report_mismatch("confidence", m_axis_tdata[79:64], e.box.conf);
				if (m_axis_tdata[86:80] !== e.box.cls) report_mismatch("class index", m_axis_tdata[86:80], e.box.cls);
				if (m_axis_tuser[1] !== e.ovf) report_mismatch("overflow", m_axis_tuser[1], e.ovf);
				if (m_axis_tlast !== e.last) report_mismatch("last", m_axis_tlast, e.last);
			end
			results_seen++;
		end
	end

	// Watchdog on cycles without any transfer.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cyc <= 0;
		end else begin
			idle_cyc <= idle_cyc + 1;
			if (idle_cyc == WDOG_LIMIT) begin
				$display("watchdog expired with %0d results outstanding", box_expect_q.size());
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	task automatic reg_write(input reg_idx_t idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= APB_AW'(4 * idx);
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_SCORE_THR:   thr_score = val[15:0];
			REG_OVERLAP_THR: thr_overlap = val[15:0];
			REG_MODEL_W:     mdl_w = val[12:0];
			REG_MODEL_H:     mdl_h = val[12:0];
			REG_CLASS_CNT:   cls_cnt = val[6:0];
			default: ;
		endcase
	endtask

	task automatic set_config(input int s, input int o, input int w, input int h, input int c);
		reg_write(REG_SCORE_THR, s);
		reg_write(REG_OVERLAP_THR, o);
		reg_write(REG_MODEL_W, w);
		reg_write(REG_MODEL_H, h);
		reg_write(REG_CLASS_CNT, c);
	endtask

	task automatic add_item(input bit op, input int sc, input int cx, input int cy,
		input int w, input int h, input bit fe);
		det_item_t it;
		it.op = op;
		it.score = 16'(sc);
		it.cx = 16'(cx);
		it.cy = 16'(cy);
		it.w = 16'(w);
		it.h = 16'(h);
		it.fe = fe;
		det_item_q.insert(det_item_q.size(), it);
		items_sent++;
	endtask

	task automatic add_anchor(input int nsc, input bit fe);
		int k, b, sc;
		sc = $urandom_range(0, 65535);
		for (k = 0; k < nsc; k++) begin
			// Repeat the previous score now and then to exercise ties.
			if ($urandom_range(0, 3) != 0) sc = $urandom_range(0, 65535);
			add_item(1'b0, sc, $urandom, $urandom, $urandom, $urandom, $urandom_range(0, 19) == 0);
		end
		if ($urandom_range(0, 4) == 0) begin
			add_item(1'b1, $urandom, $urandom, $urandom, $urandom, $urandom, fe);
		end else begin
			b = $urandom_range(0, 2);
			add_item(1'b1, $urandom, base_x[b] + $urandom_range(0, 300),
				base_y[b] + $urandom_range(0, 300), $urandom_range(200, 3000),
				$urandom_range(200, 3000), fe);
		end
	endtask

	task automatic add_frame(input int anchors, input int typ);
		int a, nsc;
		for (a = 0; a < 3; a++) begin
			base_x[a] = $urandom_range(0, 12000);
			base_y[a] = $urandom_range(0, 12000);
		end
		for (a = 0; a < anchors; a++) begin
			case ($urandom_range(0, 5))
				0: nsc = $urandom_range(0, typ);
				1: nsc = typ + $urandom_range(1, 2);
				default: nsc = typ;
			endcase
			add_anchor(nsc, a == anchors - 1);
		end
	endtask

	task automatic random_phase(input int target, input int typ);
		int stop_at;
		stop_at = items_sent + target;
		while (items_sent < stop_at) add_frame($urandom_range(1, 8), typ);
	endtask

	task automatic drain();
		do @(negedge clk);
		while (det_item_q.size() > 0 || s_axis_tvalid || box_expect_q.size() > 0);
		repeat (SETTLE_CYC) @(negedge clk);
	endtask

	initial begin
		int a;
		best_sc = 0;
		best_cl = 0;
		cls_seen = 0;
		cand_n = 0;
		ovf_flag = 0;
		idle_cyc = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Reset settings: ties, extreme box fields, a box with no scores,
		// and a frame end flag on a score item that must be ignored.
		add_item(1'b0, 0, 0, 0, 0, 0, 1'b0);
		add_item(1'b0, 65535, 0, 0, 0, 0, 1'b0);
		add_item(1'b0, 65535, 0, 0, 0, 0, 1'b1);
		add_item(1'b1, 0, 0, 65535, 65535, 0, 1'b0);
		add_item(1'b1, 0, 5000, 5000, 800, 800, 1'b0);
		add_item(1'b0, 40000, 0, 0, 0, 0, 1'b0);
		add_item(1'b1, 0, 65535, 0, 0, 65535, 1'b1);
		// A frame that keeps nothing.
		add_item(1'b1, 0, 100, 100, 100, 100, 1'b1);
		drain();

		// Lowest thresholds, zero model width, widest height, two classes:
		// extra scores, zero-area boxes and heavy overlap.
		set_config(1, 1, 0, 8191, 2);
		add_item(1'b0, 5, 0, 0, 0, 0, 1'b0);
		add_item(1'b0, 5, 0, 0, 0, 0, 1'b0);
		add_item(1'b0, 9, 0, 0, 0, 0, 1'b0);
		add_item(1'b1, 0, 16, 16, 0, 0, 1'b0);
		add_item(1'b0, 7, 0, 0, 0, 0, 1'b0);
		add_item(1'b1, 0, 16, 16, 0, 0, 1'b0);
		add_item(1'b0, 3, 0, 0, 0, 0, 1'b0);
		add_item(1'b0, 8, 0, 0, 0, 0, 1'b0);
		add_item(1'b1, 0, 8, 8, 4, 4, 1'b0);
		add_item(1'b0, 8, 0, 0, 0, 0, 1'b0);
		add_item(1'b1, 0, 8, 8, 4, 4, 1'b1);
		drain();

		// Default thresholds and model size, four classes, with a long receiver hold-off, so input backs up.
		set_config(16384, 29491, 640, 640, 4);
		hold_req = 1'b1;
		random_phase(35, 4);
		drain();

		set_config(65535, 65535, 4096, 1, 3);
		random_phase(25, 3);
		drain();

		set_config(1, 1, 1, 4096, 1);
		random_phase(25, 1);
		drain();

		// No scores are counted, so nothing qualifies.
		set_config(8000, 40000, 320, 320, 0);
		random_phase(15, 2);
		drain();

		// Class count above the maximum: scores past the limit are ignored.
		set_config(500, 20000, 1000, 700, 127);
		add_frame(1, 82);
		random_phase(20, 3);
		drain();

		// Store overflow: more qualifying anchors than the store holds.
		set_config(1, 65535, 640, 640, 1);
		for (a = 0; a < MAX_BOXES + 2; a++)
			add_item(1'b0, $urandom_range(1, 65535), 0, 0, 0, 0, 1'b0);
		for (a = 0; a < MAX_BOXES + 2; a++) begin
			det_item_t it;
			it = det_item_q[a];
			it.op = 1'b1;
			it.cx = 16'($urandom_range(0, 10000));
			it.cy = 16'($urandom_range(0, 10000));
			it.w = 16'($urandom_range(16, 400));
			it.h = 16'($urandom_range(16, 400));
			it.fe = a == MAX_BOXES + 1;
			det_item_q.insert(2 * a + 1, it);
			items_sent++;
		end
		drain();

		// Final stretch without any idling.
		set_config(20000, 30000, 640, 480, 5);
		calm = 1'b1;
		random_phase(25, 5);
		drain();

		$display("covered %0d input items in %0d frames (%0d with no kept box)",
			items_sent, frames_done, empty_frames);
		$display("checked %0d results over nine register settings", results_seen);
		if (err_cnt == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches", err_cnt);
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
`default_nettype wire

// File: detection_decode_nms_top.f
rtl/dnms_pkg.sv
rtl/dnms_ram.sv
rtl/dnms_div.sv
rtl/dnms_cfg.sv
rtl/dnms_datapath.sv
rtl/dnms_ctrl.sv
rtl/detection_decode_nms_top.sv
rtl/dnms_checker.sv
tb/sv/tb_detection_decode_nms_top.sv
